// ===== design/hmr_pkg.sv =====
// shared types and constants for the histogram max rectangle block
`timescale 1ns / 1ps

package hmr_pkg;

   localparam int MAX_BARS_DEFAULT    = 1024;
   localparam int HEIGHT_BITS_DEFAULT = 32;
   localparam int HEIGHT_W            = 32;
   localparam int AREA_W              = 42;
   localparam int POS_W               = 17;

   typedef struct packed {
      logic [HEIGHT_W-1:0] height;
      logic                last_bar;
   } req_type;

   typedef struct packed {
      logic [AREA_W-1:0] max_area;
      logic              overflowed;
   } rsp_type;

   // classified bar as handed from front to back
   typedef struct packed {
      req_type          bar;
      logic             skip;
      logic [POS_W-1:0] pos;
   } work_type;

   typedef struct packed {
      logic stack_empty;
      logic flushing;
   } status_type;

endpackage

// ===== design/hmr_front.sv =====
// bar counter, overflow classification and two-entry work queue
`timescale 1ns / 1ps

module hmr_front #(
   parameter int MAX_BARS = hmr_pkg::MAX_BARS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hmr_pkg::req_type  req_data,
   output logic              wk_valid,
   input  logic              wk_ready,
   output hmr_pkg::work_type wk_data
);

   localparam int CNT_W = $clog2(MAX_BARS + 1);

   logic [CNT_W-1:0]  bar_count_ff, bar_count_in;
   hmr_pkg::work_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push, pop, skip;
   hmr_pkg::work_type entry;

   assign req_ready = (count_ff != 2'd2);
   assign wk_valid  = (count_ff != 2'd0);
   assign wk_data   = slot_ff[rd_ptr_ff];

   assign push = req_valid && req_ready;
   assign pop  = wk_valid && wk_ready;
   assign skip = (bar_count_ff == CNT_W'(MAX_BARS));

   always_comb begin
      entry.bar  = req_data;
      entry.skip = skip;
      entry.pos  = hmr_pkg::POS_W'(bar_count_ff);
   end

   always_comb begin
      bar_count_in = bar_count_ff;
      if (push) begin
         if (req_data.last_bar) begin
            bar_count_in = '0;
         end else if (!skip) begin
            bar_count_in = bar_count_ff + CNT_W'(1);
         end
      end
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bar_count_ff <= '0;
         wr_ptr_ff    <= 1'b0;
         rd_ptr_ff    <= 1'b0;
         count_ff     <= 2'd0;
      end else begin
         bar_count_ff <= bar_count_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

// ===== design/hmr_back.sv =====
// monotonic stack engine, area fold and result register
`timescale 1ns / 1ps

module hmr_back #(
   parameter int MAX_BARS    = hmr_pkg::MAX_BARS_DEFAULT,
   parameter int HEIGHT_BITS = hmr_pkg::HEIGHT_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wk_valid,
   output logic                wk_ready,
   input  hmr_pkg::work_type   wk_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output hmr_pkg::rsp_type    rsp_data,
   output hmr_pkg::status_type status
);

   localparam int CNT_W = $clog2(MAX_BARS + 1);
   localparam int AW    = $clog2(MAX_BARS);
   localparam int H_W   = (HEIGHT_BITS < hmr_pkg::HEIGHT_W) ? HEIGHT_BITS : hmr_pkg::HEIGHT_W;
   localparam int BW    = H_W + CNT_W;
   localparam int CMP_W = (BW > hmr_pkg::AREA_W + 1) ? BW : hmr_pkg::AREA_W + 1;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_EMIT  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] depth_ff, depth_in;
   logic [H_W-1:0]   top_h_ff, top_h_in;
   logic [H_W-1:0]   cur_h_ff, cur_h_in;
   logic [CNT_W-1:0] cur_pos_ff, cur_pos_in;
   logic             cur_last_ff, cur_last_in;
   logic             flush_ff, flush_in;
   logic [BW-1:0]    prod_ff, prod_in;
   logic             prod_valid_ff, prod_valid_in;
   logic [BW-1:0]    best_ff, best_in;
   logic             ovf_ff, ovf_in;
   logic             rsp_valid_ff, rsp_valid_in;
   hmr_pkg::rsp_type rsp_ff, rsp_in;
   logic [H_W-1:0]   rd_h_ff;
   logic [AW-1:0]    rd_i_ff;

   logic [H_W-1:0]   mem_h [MAX_BARS];
   logic [AW-1:0]    mem_i [MAX_BARS];

   logic             pop_go, push_go;
   logic [CNT_W-1:0] width;
   logic [CNT_W-1:0] rd_addr_full;
   logic [CMP_W-1:0] best_ext;

   assign wk_ready           = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_ff;
   assign status.stack_empty = (depth_ff == '0);
   assign status.flushing    = flush_ff;

   assign pop_go  = (state_ff == S_CHECK) && (depth_ff != '0)
                    && (flush_ff || (top_h_ff >= cur_h_ff));
   assign push_go = (state_ff == S_CHECK) && !pop_go && !flush_ff;
   assign width   = (depth_ff == CNT_W'(1)) ? cur_pos_ff
                                            : cur_pos_ff - CNT_W'(rd_i_ff) - CNT_W'(1);
   assign best_ext = CMP_W'(best_ff);
   // entry just below the top, for the next cycle
   assign rd_addr_full = depth_in - CNT_W'(2);

   always_comb begin
      state_in      = state_ff;
      depth_in      = depth_ff;
      top_h_in      = top_h_ff;
      cur_h_in      = cur_h_ff;
      cur_pos_in    = cur_pos_ff;
      cur_last_in   = cur_last_ff;
      flush_in      = flush_ff;
      prod_in       = prod_ff;
      prod_valid_in = 1'b0;
      ovf_in        = ovf_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      best_in       = (prod_valid_ff && (prod_ff > best_ff)) ? prod_ff : best_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (wk_valid) begin
               cur_h_in    = wk_data.bar.height[H_W-1:0];
               cur_pos_in  = wk_data.pos[CNT_W-1:0];
               cur_last_in = wk_data.bar.last_bar;
               if (wk_data.skip) begin
                  ovf_in = 1'b1;
                  if (wk_data.bar.last_bar) begin
                     flush_in = 1'b1;
                     state_in = S_CHECK;
                  end
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (pop_go) begin
               prod_in       = BW'(top_h_ff) * BW'(width);
               prod_valid_in = 1'b1;
               top_h_in      = rd_h_ff;
               depth_in      = depth_ff - CNT_W'(1);
            end else if (flush_ff) begin
               state_in = S_EMIT;
            end else begin
               top_h_in = cur_h_ff;
               depth_in = depth_ff + CNT_W'(1);
               if (cur_last_ff) begin
                  flush_in   = 1'b1;
                  cur_pos_in = cur_pos_ff + CNT_W'(1);
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.max_area = (|best_ext[CMP_W-1:hmr_pkg::AREA_W]) ? '1
                               : best_ext[hmr_pkg::AREA_W-1:0];
               rsp_in.overflowed = ovf_ff;
               best_in  = '0;
               ovf_in   = 1'b0;
               flush_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         depth_ff      <= '0;
         flush_ff      <= 1'b0;
         prod_valid_ff <= 1'b0;
         best_ff       <= '0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         depth_ff      <= depth_in;
         flush_ff      <= flush_in;
         prod_valid_ff <= prod_valid_in;
         best_ff       <= best_in;
         ovf_ff        <= ovf_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_h_ff    <= top_h_in;
      cur_h_ff    <= cur_h_in;
      cur_pos_ff  <= cur_pos_in;
      cur_last_ff <= cur_last_in;
      prod_ff     <= prod_in;
      rsp_ff      <= rsp_in;
   end

   // stack memory
   always_ff @(posedge clock) begin
      if (push_go) begin
         mem_h[depth_ff[AW-1:0]] <= cur_h_ff;
         mem_i[depth_ff[AW-1:0]] <= cur_pos_ff[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rd_h_ff <= mem_h[rd_addr_full[AW-1:0]];
      rd_i_ff <= mem_i[rd_addr_full[AW-1:0]];
   end

endmodule

// ===== design/histogram_max_rectangle.sv =====
// Largest rectangle in a histogram. Bars arrive one per beat on req_, the last one
// flagged; one beat on rsp_ follows the last bar with the largest area and an
// overflow flag for bars beyond MAX_BARS. The stack engine takes each bar from the
// input queue, pops every stacked bar at least as tall, folding its area into the
// maximum, and then pushes the bar, doing one accept, push or pop step per cycle.
// After the last bar it pops every bar still on the stack and then emits the
// result. A two-beat queue lets input be taken while the stack engine works.
`timescale 1ns / 1ps

module histogram_max_rectangle #(
   parameter int MAX_BARS    = hmr_pkg::MAX_BARS_DEFAULT,
   parameter int HEIGHT_BITS = hmr_pkg::HEIGHT_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hmr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hmr_pkg::rsp_type rsp_data
);

   logic                wk_valid;
   logic                wk_ready;
   hmr_pkg::work_type   wk_data;
   hmr_pkg::status_type st;

   hmr_front #(
      .MAX_BARS (MAX_BARS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .wk_valid  (wk_valid),
      .wk_ready  (wk_ready),
      .wk_data   (wk_data)
   );

   hmr_back #(
      .MAX_BARS    (MAX_BARS),
      .HEIGHT_BITS (HEIGHT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .wk_valid  (wk_valid),
      .wk_ready  (wk_ready),
      .wk_data   (wk_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .status    (st)
   );

`ifndef SYNTH
   a_reset_empty : assert property (@(posedge clock) reset |=> st.stack_empty)
      else $error("stack not empty after reset");

   a_emit_after_flush : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(st.stack_empty && st.flushing))
      else $error("result beat without a completed flush");
`endif

endmodule
